// ===== rtl/u16u8_pkg.sv =====
package u16u8_pkg;

  // Byte-order mark bytes.
  localparam logic [7:0] BomFe = 8'hFE;
  localparam logic [7:0] BomFf = 8'hFF;

  // High surrogate range and the base of the supplementary planes.
  localparam logic [15:0] SurHighMin = 16'hD800;
  localparam logic [15:0] SurHighMax = 16'hDBFF;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // Limits of the one- and two-byte encodings.
  localparam logic [15:0] OneByteMax = 16'h007F;
  localparam logic [15:0] TwoByteMax = 16'h07FF;

  // UTF-8 byte prefixes.
  localparam logic [1:0] ContPrefix  = 2'b10;
  localparam logic [2:0] Lead2Prefix = 3'b110;
  localparam logic [3:0] Lead3Prefix = 4'b1110;
  localparam logic [4:0] Lead4Prefix = 5'b11110;

  // Encoding length codes: number of output bytes minus one.
  localparam logic [1:0] Len1 = 2'd0;
  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  localparam int unsigned DefaultQueueDepth = 4;

  // One character (or one mark error) waiting to be serialised.
  typedef struct packed {
    logic        err;
    logic [1:0]  len;
    logic [20:0] cp;
  } entry_t;

  // Write side of the queue.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  // Read side of the queue.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

// ===== rtl/u16u8_if.sv =====
interface u16u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== rtl/u16u8_front.sv =====
module u16u8_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  u16u8_in_if.sink             in_i,
  input  logic                 q_ready_i,
  output u16u8_pkg::q_push_t   push_o
);
  import u16u8_pkg::*;

  localparam logic [1:0] PhMark1 = 2'd0;
  localparam logic [1:0] PhMark2 = 2'd1;
  localparam logic [1:0] PhData  = 2'd2;
  localparam logic [1:0] PhHalt  = 2'd3;

  logic [1:0]  phase_q, phase_d, phase_eff;
  logic        le_q, le_d;
  logic [7:0]  mark_q, mark_d;
  logic [7:0]  held_q, held_d;
  logic        half_q, half_d;
  logic        sur_q, sur_d;
  logic [9:0]  hi_q, hi_d;
  logic        accept;
  logic [15:0] unit;
  logic [20:0] cp_supp;
  logic [1:0]  unit_len;
  q_push_t     push;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign phase_eff  = in_i.stream_start ? PhMark1 : phase_q;

  assign unit    = le_q ? {in_i.in_byte, held_q} : {held_q, in_i.in_byte};
  assign cp_supp = SuppBase + {1'b0, hi_q, unit[9:0]};

  always_comb begin
    if (unit <= OneByteMax) begin
      unit_len = Len1;
    end else if (unit <= TwoByteMax) begin
      unit_len = Len2;
    end else begin
      unit_len = Len3;
    end
  end

  always_comb begin
    phase_d = phase_q;
    le_d    = le_q;
    mark_d  = mark_q;
    held_d  = held_q;
    half_d  = half_q;
    sur_d   = sur_q;
    hi_d    = hi_q;
    push    = '0;
    if (accept) begin
      unique case (phase_eff)
        PhMark1: begin
          mark_d  = in_i.in_byte;
          phase_d = PhMark2;
        end
        PhMark2: begin
          half_d = 1'b0;
          sur_d  = 1'b0;
          if (mark_q == BomFe && in_i.in_byte == BomFf) begin
            le_d    = 1'b0;
            phase_d = PhData;
          end else if (mark_q == BomFf && in_i.in_byte == BomFe) begin
            le_d    = 1'b1;
            phase_d = PhData;
          end else begin
            phase_d          = PhHalt;
            push.valid       = 1'b1;
            push.entry.err   = 1'b1;
            push.entry.len   = Len1;
            push.entry.cp    = '0;
          end
        end
        PhData: begin
          if (!half_q) begin
            held_d = in_i.in_byte;
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            if (sur_q) begin
              sur_d          = 1'b0;
              push.valid     = 1'b1;
              push.entry.len = Len4;
              push.entry.cp  = cp_supp;
            end else if (unit >= SurHighMin && unit <= SurHighMax) begin
              sur_d = 1'b1;
              hi_d  = unit[9:0];
            end else begin
              push.valid     = 1'b1;
              push.entry.len = unit_len;
              push.entry.cp  = {5'd0, unit};
            end
          end
        end
        PhHalt: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMark1;
      le_q    <= 1'b0;
      half_q  <= 1'b0;
      sur_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      le_q    <= le_d;
      half_q  <= half_d;
      sur_q   <= sur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_q <= mark_d;
    held_q <= held_d;
    hi_q   <= hi_d;
  end

  // A character or an error is only ever produced by an accepted word.
  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> accept)
    else $error("front pushed without an accepted word");

  // Once halted on a bad mark, only a new stream leaves the halt.
  a_halt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHalt && !(accept && in_i.stream_start)) |=> phase_q == PhHalt)
    else $error("left halt without a stream start");
endmodule

// ===== rtl/u16u8_fifo.sv =====
module u16u8_fifo #(
  parameter int unsigned Depth = u16u8_pkg::DefaultQueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  u16u8_pkg::q_push_t   push_i,
  output logic                 ready_o,
  output u16u8_pkg::q_head_t   head_o,
  input  logic                 pop_i
);
  import u16u8_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  entry_t           mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o      = (cnt_q != FullCnt);
  assign do_push      = push_i.valid;
  assign do_pop       = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  // The front only writes when there is room.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> ready_o)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");
endmodule

// ===== rtl/u16u8_back.sv =====
module u16u8_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  u16u8_pkg::q_head_t   head_i,
  output logic                 pop_o,
  u16u8_out_if.source          out_o
);
  import u16u8_pkg::*;

  entry_t     cur_q;
  logic       cur_v_q, cur_v_d;
  logic [1:0] idx_q, idx_d;
  logic       fire, is_last, pop;
  logic [7:0] byte_w;

  assign is_last = (idx_q == cur_q.len);
  assign fire    = cur_v_q && out_o.ready;
  assign pop     = head_i.valid && (!cur_v_q || (fire && is_last));
  assign pop_o   = pop;

  // Byte selection by encoding length and position within the character.
  always_comb begin
    byte_w = '0;
    if (!cur_q.err) begin
      unique case (cur_q.len)
        Len1: byte_w = {1'b0, cur_q.cp[6:0]};
        Len2: begin
          if (idx_q == 2'd0) byte_w = {Lead2Prefix, cur_q.cp[10:6]};
          else               byte_w = {ContPrefix, cur_q.cp[5:0]};
        end
        Len3: begin
          unique case (idx_q)
            2'd0:    byte_w = {Lead3Prefix, cur_q.cp[15:12]};
            2'd1:    byte_w = {ContPrefix, cur_q.cp[11:6]};
            default: byte_w = {ContPrefix, cur_q.cp[5:0]};
          endcase
        end
        Len4: begin
          unique case (idx_q)
            2'd0:    byte_w = {Lead4Prefix, cur_q.cp[20:18]};
            2'd1:    byte_w = {ContPrefix, cur_q.cp[17:12]};
            2'd2:    byte_w = {ContPrefix, cur_q.cp[11:6]};
            default: byte_w = {ContPrefix, cur_q.cp[5:0]};
          endcase
        end
        default: byte_w = '0;
      endcase
    end
  end

  assign out_o.valid    = cur_v_q;
  assign out_o.out_byte = byte_w;
  assign out_o.status   = cur_q.err;
  assign out_o.last     = is_last;

  always_comb begin
    cur_v_d = cur_v_q;
    idx_d   = idx_q;
    if (pop) begin
      cur_v_d = 1'b1;
      idx_d   = '0;
    end else if (fire) begin
      if (is_last) begin
        cur_v_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      cur_v_q <= cur_v_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= head_i.entry;
    end
  end

  // The byte position never runs past the character's length.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> idx_q <= cur_q.len)
    else $error("byte index beyond encoding length");
endmodule

// ===== rtl/utf16_to_utf8_stream.sv =====
// A word that completes a character is written into the queue, then loaded into the
// back's character register before its first UTF-8 word appears. Throughput: one input
// word per cycle while the queue has room, one output word per cycle while out ready is
// high; the output serialiser sets the sustained rate for characters of three bytes.
// Reset: asynchronous, active low; the block waits for a first mark byte, queue empty.
module utf16_to_utf8_stream #(
  parameter int unsigned QueueDepth = u16u8_pkg::DefaultQueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  u16u8_in_if.sink     in_i,
  u16u8_out_if.source  out_o
);
  import u16u8_pkg::*;

  // The front checks the byte-order mark, pairs bytes into code units and
  // joins surrogates. Every finished character, or a mark error, is written
  // into the queue as one entry carrying the code point and its UTF-8 length.
  // The back takes one entry at a time and hands out one word per cycle while the
  // output is ready, marking the final word of each character. The queue lets the front keep
  // taking words while the back is still busy with a long encoding.
  q_push_t push;
  q_head_t head;
  logic    q_ready;
  logic    pop;

  u16u8_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  u16u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  // The back holds the current character in its own register, which acts
  // as the output register: a new entry is loaded in the same cycle that
  // the last word of the previous one is taken.
  u16u8_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // An error word always ends its own group.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |-> (out_o.last && out_o.out_byte == 8'h00))
    else $error("error word malformed");
endmodule

// ===== sim/utf16_to_utf8_stream_tb.sv =====
module utf16_to_utf8_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  // Meaning of the status bit on the output side.
  localparam logic StatusData    = 1'b0;
  localparam logic StatusBadMark = 1'b1;

  // Code-unit ranges that the package does not name.
  localparam logic [15:0] LowSurMin = 16'hDC00;
  localparam logic [20:0] BmpMax    = 21'h00FFFF;

  // Run shape.
  localparam int IdlePct     = 35;
  localparam int RandomItems = 150;
  localparam int HoldAfter   = 40;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 100000;

  // Decoder phases, mirrored from the block's behaviour.
  typedef enum logic [1:0] {
    PhMark1,
    PhMark2,
    PhDecode,
    PhHalted
  } phase_e;

  // One output word as the receiver sees it.
  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       last;
  } utf8_word_t;

  // One row of the directed table. Where typed is set, the expected words are taken from
  // n and bytes (first word in the top byte) rather than from the predictor; bad_mark
  // turns them into the error word.
  typedef struct packed {
    logic [7:0]      b;
    logic            start;
    logic            typed;
    logic            bad_mark;
    logic [2:0]      n;
    logic [0:3][7:0] bytes;
  } stim_row_t;

  // Columns: byte, stream_start, typed, bad_mark, word count, expected bytes.
  localparam stim_row_t DirectedRows [27] = '{
    // A big-endian mark opens the first stream.
    '{8'hFE, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    // U+0000 must come out as a single zero byte.
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 3'd1, 32'h00_00_00_00},
    // Top of the one-byte range.
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h7F, 1'b0, 1'b1, 1'b0, 3'd1, 32'h7F_00_00_00},
    // Top of the two-byte range.
    '{8'h07, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 3'd2, 32'hDF_BF_00_00},
    // Top of the basic plane.
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 3'd3, 32'hEF_BF_BF_00},
    // Highest high surrogate followed by a plain letter, joined without a check.
    '{8'hDB, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h41, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    // A low surrogate on its own is an ordinary three-byte value.
    '{8'hDF, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    // Pending high surrogate plus an odd byte: the tail is dropped by the next stream.
    '{8'hD8, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h12, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    // Little-endian stream carrying the lowest supplementary character.
    '{8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hFE, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hD8, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hDC, 1'b0, 1'b1, 1'b0, 3'd4, 32'hF0_90_80_80},
    // A bad mark gives exactly one error word.
    '{8'h00, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h41, 1'b0, 1'b1, 1'b1, 3'd1, 32'h00_00_00_00}
  };

  logic clk;
  logic rst_n;

  u16u8_in_if  in_bus ();
  u16u8_out_if out_bus ();

  utf16_to_utf8_stream dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Words still owed by the block, oldest first.
  utf8_word_t pending_utf8_q [$];

  int  err_count   = 0;
  int  rx_words    = 0;
  int  live_items  = 0;
  int  cycle_count = 0;
  bit  calm        = 1'b0;

  // Our own copy of the decoder state.
  phase_e     phase;
  logic       little_end;
  logic [7:0] mark_byte;
  logic [7:0] held_byte;
  logic       half_full;
  logic       high_waiting;
  logic [9:0] high_bits;

  // 2 ns clock, low half first.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case the block locks up.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_stream_state();
    phase        = PhMark1;
    little_end   = 1'b0;
    mark_byte    = '0;
    held_byte    = '0;
    half_full    = 1'b0;
    high_waiting = 1'b0;
    high_bits    = '0;
  endfunction

  function automatic utf8_word_t data_word(input logic [7:0] d, input logic lst);
    return '{data: d, status: StatusData, last: lst};
  endfunction

  // Splits a code point into its UTF-8 words; the count is returned.
  function automatic int encode_utf8(input logic [20:0] cp, output utf8_word_t [0:3] w);
    w = '0;
    if (cp <= OneByteMax) begin
      w[0] = data_word(cp[7:0], 1'b1);
      return 1;
    end
    if (cp <= TwoByteMax) begin
      w[0] = data_word({Lead2Prefix, cp[10:6]}, 1'b0);
      w[1] = data_word({ContPrefix, cp[5:0]}, 1'b1);
      return 2;
    end
    if (cp <= BmpMax) begin
      w[0] = data_word({Lead3Prefix, cp[15:12]}, 1'b0);
      w[1] = data_word({ContPrefix, cp[11:6]}, 1'b0);
      w[2] = data_word({ContPrefix, cp[5:0]}, 1'b1);
      return 3;
    end
    w[0] = data_word({Lead4Prefix, cp[20:18]}, 1'b0);
    w[1] = data_word({ContPrefix, cp[17:12]}, 1'b0);
    w[2] = data_word({ContPrefix, cp[11:6]}, 1'b0);
    w[3] = data_word({ContPrefix, cp[5:0]}, 1'b1);
    return 4;
  endfunction

  // Advances the decoder by one accepted byte and returns the words it should produce.
  function automatic int transcode_byte(input logic [7:0] b, input logic s,
                                        output utf8_word_t [0:3] w);
    logic [15:0] unit;
    logic [20:0] cp;
    w = '0;
    if (s) clear_stream_state();
    case (phase)
      PhMark1: begin
        mark_byte = b;
        phase     = PhMark2;
        return 0;
      end
      PhMark2: begin
        if (mark_byte == BomFe && b == BomFf) begin
          little_end = 1'b0;
        end else if (mark_byte == BomFf && b == BomFe) begin
          little_end = 1'b1;
        end else begin
          phase = PhHalted;
          w[0]  = '{data: 8'h00, status: StatusBadMark, last: 1'b1};
          return 1;
        end
        half_full    = 1'b0;
        high_waiting = 1'b0;
        phase        = PhDecode;
        return 0;
      end
      PhHalted: return 0;
      default: ;
    endcase
    if (!half_full) begin
      held_byte = b;
      half_full = 1'b1;
      return 0;
    end
    half_full = 1'b0;
    unit = little_end ? {b, held_byte} : {held_byte, b};
    if (high_waiting) begin
      // Whatever follows a high surrogate is joined on its low ten bits alone.
      high_waiting = 1'b0;
      cp = SuppBase + {1'b0, high_bits, unit[9:0]};
      return encode_utf8(cp, w);
    end
    if (unit >= SurHighMin && unit <= SurHighMax) begin
      high_waiting = 1'b1;
      high_bits    = unit[9:0];
      return 0;
    end
    return encode_utf8({5'b0, unit}, w);
  endfunction

  // Offers one word and returns at the edge where it is taken. The valid line is only
  // lowered during an idle gap, so it never sees two assignments in one time step.
  task automatic send_word(input logic [7:0] b, input logic s);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.in_byte      <= b;
    in_bus.stream_start <= s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic s);
    utf8_word_t [0:3] w;
    int               n;
    logic             ignored;
    ignored = !s && phase == PhHalted;
    send_word(b, s);
    n = transcode_byte(b, s, w);
    for (int k = 0; k < n; k++) pending_utf8_q.push_back(w[k]);
    if (!ignored) live_items++;
  endtask

  task automatic feed_unit(input logic le, input logic [15:0] u);
    if (le) begin
      feed_byte(u[7:0], 1'b0);
      feed_byte(u[15:8], 1'b0);
    end else begin
      feed_byte(u[15:8], 1'b0);
      feed_byte(u[7:0], 1'b0);
    end
  endtask

  // One character drawn from every size class, with surrogate oddities mixed in.
  task automatic send_random_char(input logic le);
    case ($urandom_range(7))
      0: feed_unit(le, 16'($urandom_range(OneByteMax)));
      1: feed_unit(le, 16'($urandom_range(TwoByteMax, OneByteMax + 1)));
      2: feed_unit(le, 16'($urandom));
      3, 4: begin
        feed_unit(le, SurHighMin | 16'($urandom_range(10'h3FF)));
        feed_unit(le, LowSurMin | 16'($urandom_range(10'h3FF)));
      end
      5: begin
        feed_unit(le, SurHighMin | 16'($urandom_range(10'h3FF)));
        feed_unit(le, 16'($urandom));
      end
      6: feed_unit(le, LowSurMin | 16'($urandom_range(10'h3FF)));
      default: begin
        case ($urandom_range(5))
          0:       feed_unit(le, 16'h0000);
          1:       feed_unit(le, OneByteMax);
          2:       feed_unit(le, OneByteMax + 16'd1);
          3:       feed_unit(le, TwoByteMax);
          4:       feed_unit(le, TwoByteMax + 16'd1);
          default: feed_unit(le, 16'hFFFF);
        endcase
      end
    endcase
  endtask

  // Receiver: checks every word taken, and drives ready with random stalls. Once, after a
  // few dozen words, it holds ready low for a long stretch so that the queue in the block
  // fills and the input side backs up.
  initial begin : receiver
    utf8_word_t want;
    int         hold_left;
    bit         hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        rx_words++;
        if (pending_utf8_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word, expected none, got %02h status %0b last %0b",
                   $time, out_bus.out_byte, out_bus.status, out_bus.last);
        end else begin
          want = pending_utf8_q.pop_front();
          if (out_bus.out_byte !== want.data) begin
            err_count++;
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.data, out_bus.out_byte);
          end
          if (out_bus.status !== want.status) begin
            err_count++;
            $display("%0t: status expected %0b, got %0b", $time, want.status, out_bus.status);
          end
          if (out_bus.last !== want.last) begin
            err_count++;
            $display("%0t: last expected %0b, got %0b", $time, want.last, out_bus.last);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && rx_words >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Sender: the directed table first, then random streams until enough bytes have been
  // decoded. Bytes swallowed after a bad mark are not counted.
  initial begin : stimulus
    stim_row_t        r;
    utf8_word_t [0:3] w;
    int               kind;
    int               tail;
    logic             le;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.in_byte      = '0;
    in_bus.stream_start = 1'b0;
    clear_stream_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DirectedRows[i]) begin
      r = DirectedRows[i];
      if (!r.typed) begin
        feed_byte(r.b, r.start);
      end else begin
        send_word(r.b, r.start);
        void'(transcode_byte(r.b, r.start, w));
        for (int k = 0; k < r.n; k++) begin
          pending_utf8_q.push_back(utf8_word_t'{data: r.bytes[k],
                                   status: r.bad_mark ? StatusBadMark : StatusData,
                                   last: k == r.n - 1});
        end
      end
    end

    live_items = 0;
    while (live_items < RandomItems) begin
      // A stretch in the middle runs with no idling on either side.
      calm = live_items >= 70 && live_items < 110;
      kind = $urandom_range(99);
      if (kind < 75) begin
        // Well-formed stream, sometimes left with a truncated tail.
        le = 1'($urandom_range(1));
        feed_byte(le ? BomFf : BomFe, 1'b1);
        feed_byte(le ? BomFe : BomFf, 1'b0);
        repeat ($urandom_range(8, 1)) send_random_char(le);
        tail = $urandom_range(4);
        if (tail == 0) begin
          feed_byte(8'($urandom), 1'b0);
        end else if (tail == 1) begin
          feed_unit(le, SurHighMin | 16'($urandom_range(10'h3FF)));
        end
      end else if (kind < 87) begin
        // Random mark, nearly always bad, then a few bytes the block should ignore.
        feed_byte(8'($urandom), 1'b1);
        feed_byte(8'($urandom), 1'b0);
        repeat ($urandom_range(3)) feed_byte(8'($urandom), 1'b0);
      end else begin
        // Noise, with the odd stream start in awkward places.
        repeat ($urandom_range(6, 1)) feed_byte(8'($urandom), $urandom_range(7) == 0);
      end
    end
    calm = 1'b0;
    in_bus.valid <= 1'b0;

    while (pending_utf8_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
